@@ hw/rtl/crcgc_pkg.sv @@
// Shared constants and codes for the bit-serial CRC generator and checker.
package crcgc_pkg;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DEG_W     = 6;
  localparam int LEN_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GEN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_LEN  = 2'd3;

  localparam logic [CFG_W-1:0] GEN_LOW_RST = 32'h0000_1021;
  localparam logic [DEG_W-1:0] DEGREE_RST  = 6'd16;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BIT_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LEN_ERR = 2'd2;

endpackage

@@ hw/rtl/crcgc_div_step.sv @@
// One step of modulo-2 long division: shift in a bit and subtract the generator on overflow.
module crcgc_div_step #(
  parameter int MAX_DEGREE = 32
) (
  input  logic [MAX_DEGREE-1:0] rem_i,
  input  logic [MAX_DEGREE-1:0] gen_i,
  input  logic [MAX_DEGREE-1:0] mask_i,
  input  logic [MAX_DEGREE-1:0] top_sel_i,
  input  logic                  bit_i,
  output logic [MAX_DEGREE-1:0] rem_o,
  output logic                  top_o
);

  logic [MAX_DEGREE-1:0] rem_m;
  logic [MAX_DEGREE-1:0] shifted;

  assign rem_m   = rem_i & mask_i;
  assign top_o   = |(rem_m & top_sel_i);
  assign shifted = ((rem_m << 1) | MAX_DEGREE'(bit_i)) & mask_i;
  assign rem_o   = top_o ? (shifted ^ (gen_i & mask_i)) : shifted;

endmodule

@@ hw/rtl/crc_generate_and_check_core.sv @@
// Top level of the bit-serial CRC generator and checker with a configurable generator.
//
// Input beats carry one message bit each, most significant first, in s_axis_tdata[0];
// s_axis_tlast marks the last bit of a run. Every bit runs one long division step, so
// the input takes one beat per cycle while a run is in progress and no output beat waits.
// In generate mode the last bit is followed by degree zero-bit division steps, one per
// cycle, and then by degree output beats carrying the remainder MSB first in
// m_axis_tdata[0], with m_axis_tlast on the final one. A generate run therefore holds
// the input until its final output beat is issued, and longer while the receiver stalls.
// In check mode the last bit produces one output beat in the next cycle whose tuser holds
// the status: ok, bit error (nonzero remainder) or length error (fewer bits than the
// expected length); the next run may start in the following cycle.
// Output beats sit in a register: when the receiver stalls, the beat holds and the
// input is held until the waiting beat is taken.
// The configuration port writes one register per cycle: index 0 generator coefficients,
// 1 degree, 2 mode, 3 expected length. Write it only while no run is in progress.
// Reset clears the remainder, the bit count and the output valid flag and restores the
// configuration defaults (CRC-16 generator 0x1021, degree 16, generate mode).
module crc_generate_and_check_core #(
  parameter int MAX_DEGREE = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [crcgc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [crcgc_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [crcgc_pkg::BYTE_W-1:0]     s_axis_tdata,   // [0] message_bit, zero fill above
  input  logic                             s_axis_tlast,   // final_bit
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [crcgc_pkg::BYTE_W-1:0]     m_axis_tdata,   // [0] check_bit, zero fill above
  output logic [crcgc_pkg::STATUS_W-1:0]   m_axis_tuser,   // [1:0] status
  output logic                             m_axis_tlast    // run_end
);

  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int LW = (COUNT_BITS > crcgc_pkg::LEN_W) ? COUNT_BITS : crcgc_pkg::LEN_W;

  localparam logic [1:0] PH_RUN   = 2'd0;
  localparam logic [1:0] PH_FLUSH = 2'd1;
  localparam logic [1:0] PH_EMIT  = 2'd2;

  logic [crcgc_pkg::CFG_W-1:0]    gen_low_q;
  logic [crcgc_pkg::DEG_W-1:0]    degree_q;
  logic                           mode_q;
  logic [crcgc_pkg::LEN_W-1:0]    exp_len_q;

  logic [1:0]                     phase_q, phase_d;
  logic [MAX_DEGREE-1:0]          rem_q, rem_d;
  logic [COUNT_BITS-1:0]          cnt_q, cnt_d, cnt_inc;
  logic [DW-1:0]                  steps_q, steps_d;

  logic                           out_valid_q, out_valid_d;
  logic                           out_bit_q, out_bit_d;
  logic [crcgc_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic                           out_last_q, out_last_d;

  logic [DW-1:0]                  deg_eff;
  logic [MAX_DEGREE-1:0]          gen_ext;
  logic [MAX_DEGREE-1:0]          mask;
  logic [MAX_DEGREE-1:0]          top_sel;
  logic [MAX_DEGREE-1:0]          step_rem;
  logic                           step_top;
  logic                           step_bit;
  logic                           out_free;
  logic                           in_acc;
  logic [crcgc_pkg::STATUS_W-1:0] status_new;

  always_comb begin
    if ({1'b0, degree_q} > (crcgc_pkg::DEG_W + 1)'(MAX_DEGREE)) begin
      deg_eff = DW'(MAX_DEGREE);
    end else if (degree_q == '0) begin
      deg_eff = DW'(1);
    end else begin
      deg_eff = DW'(degree_q);
    end
  end

  for (genvar gi = 0; gi < MAX_DEGREE; gi++) begin : g_gen
    if (gi < crcgc_pkg::CFG_W) begin : g_bit
      assign gen_ext[gi] = gen_low_q[gi];
    end else begin : g_zero
      assign gen_ext[gi] = 1'b0;
    end
    assign mask[gi]    = (DW'(gi) < deg_eff);
    assign top_sel[gi] = (DW'(gi + 1) == deg_eff);
  end

  assign step_bit = (phase_q == PH_RUN) ? s_axis_tdata[0] : 1'b0;

  crcgc_div_step #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_step (
    .rem_i    (rem_q),
    .gen_i    (gen_ext),
    .mask_i   (mask),
    .top_sel_i(top_sel),
    .bit_i    (step_bit),
    .rem_o    (step_rem),
    .top_o    (step_top)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (phase_q == PH_RUN) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cnt_inc       = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);

  always_comb begin
    if (LW'(cnt_inc) < LW'(exp_len_q)) begin
      status_new = crcgc_pkg::STATUS_LEN_ERR;
    end else if (step_rem != '0) begin
      status_new = crcgc_pkg::STATUS_BIT_ERR;
    end else begin
      status_new = crcgc_pkg::STATUS_OK;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    steps_d      = steps_q;
    out_valid_d  = out_free ? 1'b0 : out_valid_q;
    out_bit_d    = out_bit_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    unique case (phase_q)
      PH_RUN: begin
        if (in_acc) begin
          if (!s_axis_tlast) begin
            rem_d = step_rem;
            cnt_d = cnt_inc;
          end else if (mode_q) begin
            rem_d        = '0;
            cnt_d        = '0;
            out_valid_d  = 1'b1;
            out_bit_d    = 1'b0;
            out_status_d = status_new;
            out_last_d   = 1'b1;
          end else begin
            rem_d   = step_rem;
            cnt_d   = '0;
            steps_d = deg_eff;
            phase_d = PH_FLUSH;
          end
        end
      end
      PH_FLUSH: begin
        rem_d   = step_rem;
        steps_d = steps_q - DW'(1);
        if (steps_q == DW'(1)) begin
          steps_d = deg_eff;
          phase_d = PH_EMIT;
        end
      end
      PH_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_bit_d    = step_top;
          out_status_d = crcgc_pkg::STATUS_OK;
          out_last_d   = (steps_q == DW'(1));
          rem_d        = (rem_q << 1) & mask;
          steps_d      = steps_q - DW'(1);
          if (steps_q == DW'(1)) begin
            rem_d   = '0;
            phase_d = PH_RUN;
          end
        end
      end
      default: begin
        phase_d = PH_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_low_q <= crcgc_pkg::GEN_LOW_RST;
      degree_q  <= crcgc_pkg::DEGREE_RST;
      mode_q    <= 1'b0;
      exp_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crcgc_pkg::CFG_GEN_LOW: gen_low_q <= cfg_wdata_i;
        crcgc_pkg::CFG_DEGREE:  degree_q  <= cfg_wdata_i[crcgc_pkg::DEG_W-1:0];
        crcgc_pkg::CFG_MODE:    mode_q    <= cfg_wdata_i[0];
        crcgc_pkg::CFG_EXP_LEN: exp_len_q <= cfg_wdata_i[crcgc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_RUN;
      rem_q       <= '0;
      cnt_q       <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bit_q    <= out_bit_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(crcgc_pkg::BYTE_W - 1){1'b0}}, out_bit_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ hw/rtl/crcgc_checker.sv @@
// Port-level assertions for the CRC generator and checker, bound to the top level.
module crcgc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [crcgc_pkg::BYTE_W-1:0]   m_axis_tdata,
  input logic [crcgc_pkg::STATUS_W-1:0] m_axis_tuser,
  input logic                           m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == crcgc_pkg::STATUS_OK)
      || (m_axis_tuser == crcgc_pkg::STATUS_BIT_ERR)
      || (m_axis_tuser == crcgc_pkg::STATUS_LEN_ERR))
    else $error("undefined status code on output");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != crcgc_pkg::STATUS_OK) |-> m_axis_tlast
      && !m_axis_tdata[0])
    else $error("error status on a beat that is not a lone status beat");

  a_zero_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[crcgc_pkg::BYTE_W-1:1] == '0)
    else $error("fill bits of output data not zero");

endmodule

bind crc_generate_and_check_core crcgc_checker u_crcgc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
